// ----- design/vmf_pkg.sv -----
`default_nettype none
package vmf_pkg;
    localparam int MaxKernel   = 5;
    localparam int MaxPaddedX  = 128;
    localparam int MaxPaddedY  = 128;
    localparam int DepthLimit  = 4096;
    localparam int SampleBits  = 16;
    localparam int XBits       = $clog2(MaxPaddedX);
    localparam int YBits       = $clog2(MaxPaddedY);
    localparam int ZBits       = $clog2(DepthLimit);
    localparam int KBits       = $clog2(MaxKernel + 1);
    localparam int SlotBits    = $clog2(MaxKernel);
    localparam int RingDepth   = MaxKernel * MaxPaddedY * MaxPaddedX;
    localparam int RingBits    = $clog2(RingDepth);
    localparam int WinDepth    = MaxKernel * MaxKernel * MaxKernel;
    localparam int WinBits     = $clog2(WinDepth + 1);
    localparam int CfgIdxBits  = 3;
    localparam int CfgDataBits = 13;

    typedef enum logic [CfgIdxBits-1:0] {
        REG_KERNEL_X = 3'd0,
        REG_KERNEL_Y = 3'd1,
        REG_KERNEL_Z = 3'd2,
        REG_PAD_W    = 3'd3,
        REG_PAD_H    = 3'd4,
        REG_PAD_D    = 3'd5
    } t_reg_idx;

    // Request from the sequencer to the rank selection unit.
    typedef struct packed {
        logic                  start;
        logic [WinBits-1:0]    count;
        logic [WinBits-1:0]    rank;
    } t_sel_req;
endpackage
`default_nettype wire

// ----- design/vmf_select.sv -----
`default_nettype none
// Rank selection over the gathered window. For each candidate in turn, one
// compare unit sweeps all elements, counting smaller and equal values; the
// candidate whose rank interval holds the target rank is the result.
module vmf_select
    import vmf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_wr_en,
    input  wire logic [WinBits-1:0]    i_wr_addr,
    input  wire logic [SampleBits-1:0] i_wr_data,
    input  wire t_sel_req              i_req,
    output logic                       o_done,
    output logic [SampleBits-1:0]      o_value
);
    typedef enum logic [1:0] {S_IDLE, S_CAND, S_SWEEP, S_CHECK} t_state;

    logic [SampleBits-1:0] r_win [WinDepth];
    logic [SampleBits-1:0] r_rd;
    logic [WinBits-1:0]    r_rd_addr;
    t_state                r_state;
    logic [WinBits-1:0]    r_count, r_rank, r_cand, r_idx;
    logic [WinBits-1:0]    r_less, r_equal;
    logic [SampleBits-1:0] r_cval;
    logic                  r_rd_ok;

    // Window store with a registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_win[i_wr_addr[$clog2(WinDepth)-1:0]] <= i_wr_data;
        end
        r_rd <= r_win[r_rd_addr[$clog2(WinDepth)-1:0]];
    end

    // Sequencer: read candidate, then sweep all elements against it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done  <= 1'b0;
            r_rd_ok <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_count   <= i_req.count;
                        r_rank    <= i_req.rank;
                        r_cand    <= '0;
                        r_rd_addr <= '0;
                        r_rd_ok   <= 1'b0;
                        r_state   <= S_CAND;
                    end
                end
                S_CAND: begin
                    // Data of the candidate arrives in the cycle after its address.
                    if (r_rd_ok) begin
                        r_cval    <= r_rd;
                        r_less    <= '0;
                        r_equal   <= '0;
                        r_idx     <= '0;
                        r_rd_addr <= '0;
                        r_rd_ok   <= 1'b0;
                        r_state   <= S_SWEEP;
                    end else begin
                        r_rd_ok <= 1'b1;
                    end
                end
                S_SWEEP: begin
                    if (r_rd_ok) begin
                        if (r_rd < r_cval) r_less <= r_less + 1'b1;
                        if (r_rd == r_cval) r_equal <= r_equal + 1'b1;
                        r_idx <= r_idx + 1'b1;
                        if (r_idx + 1'b1 == r_count) r_state <= S_CHECK;
                    end
                    r_rd_addr <= r_rd_addr + 1'b1;
                    r_rd_ok   <= 1'b1;
                end
                S_CHECK: begin
                    if (r_less <= r_rank && r_rank < r_less + r_equal) begin
                        o_value <= r_cval;
                        o_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_cand    <= r_cand + 1'b1;
                        r_rd_addr <= r_cand + 1'b1;
                        r_rd_ok   <= 1'b0;
                        r_state   <= S_CAND;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> r_state == S_IDLE) else $error("done outside idle");
    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SWEEP |-> r_idx < r_count) else $error("sweep overrun");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CHECK |-> r_less + r_equal <= r_count) else $error("bad counts");
endmodule
`default_nettype wire

// ----- design/volume_median_filter.sv -----
`default_nettype none
// Streaming 3-D median filter. Voxels of a padded volume arrive in raster
// order (x fastest); the last kernel_z planes sit in a single-port plane
// memory. When a voxel completes a window, the window (up to 125 values) is
// gathered one value per cycle while no register write comes in, and the
// lower median is found by a shared compare unit that ranks candidates one
// sweep at a time. A voxel that completes no window is only written to the
// plane memory. One that completes a window is written, its window is
// gathered, candidates are tried in turn (at most one per window value),
// each with a sweep over all window values, until one holds the median,
// and the result is picked up and loaded into the output register; no new
// voxel is accepted before then. The result waits in the output register,
// so the next voxel can be taken while it is still pending; a result that
// finds the output register still full holds the block until it drains. Any
// register write restarts the volume at the origin.
module volume_median_filter
    import vmf_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CfgIdxBits-1:0]  i_cfg_idx,
    input  wire logic [CfgDataBits-1:0] i_cfg_data,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [15:0]            s_axis_tdata,  // sample[15:0]
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [15:0]                 m_axis_tdata,  // median[15:0]
    output logic                        m_axis_tlast
);
    typedef enum logic [2:0] {ST_IDLE, ST_WRITE, ST_GATHER, ST_SELECT, ST_OUT} t_state;

    logic [2:0]  r_kx, r_ky, r_kz;
    logic [7:0]  r_pw, r_ph;
    logic [12:0] r_pd;
    logic [XBits-1:0] r_x;
    logic [YBits-1:0] r_y;
    logic [ZBits-1:0] r_z;
    logic [SlotBits-1:0] r_slot;
    t_state r_state;
    logic [SampleBits-1:0] r_sample;

    // Clamped geometry.
    logic [KBits-1:0] kx, ky, kz;
    logic [XBits:0]   pw;
    logic [YBits:0]   ph;
    logic [ZBits:0]   pd;
    always_comb begin
        kx = (r_kx == 0) ? KBits'(1) : (r_kx > MaxKernel) ? KBits'(MaxKernel) : r_kx;
        ky = (r_ky == 0) ? KBits'(1) : (r_ky > MaxKernel) ? KBits'(MaxKernel) : r_ky;
        kz = (r_kz == 0) ? KBits'(1) : (r_kz > MaxKernel) ? KBits'(MaxKernel) : r_kz;
        pw = (r_pw == 0) ? (XBits+1)'(1) : (r_pw > MaxPaddedX) ? (XBits+1)'(MaxPaddedX)
                                                               : (XBits+1)'(r_pw);
        ph = (r_ph == 0) ? (YBits+1)'(1) : (r_ph > MaxPaddedY) ? (YBits+1)'(MaxPaddedY)
                                                               : (YBits+1)'(r_ph);
        pd = (r_pd == 0) ? (ZBits+1)'(1) : (r_pd > DepthLimit) ? (ZBits+1)'(DepthLimit)
                                                               : r_pd;
    end

    // Window completion and last flag at the current position.
    logic win_ok, is_last;
    assign win_ok = ({1'b0, r_x} + 1'b1 >= kx) && ({1'b0, r_y} + 1'b1 >= ky)
                 && ({1'b0, r_z} + 1'b1 >= kz);
    assign is_last = ({1'b0, r_x} + 1'b1 == pw) && ({1'b0, r_y} + 1'b1 == ph)
                  && ({1'b0, r_z} + 1'b1 == pd);

    // Plane memory, one port, registered read.
    logic [SampleBits-1:0] r_ring [RingDepth];
    logic [SampleBits-1:0] r_ring_q;
    logic [RingBits-1:0]   ring_addr;
    logic                  ring_we;
    logic [SlotBits-1:0]   r_gs;
    logic [KBits-1:0]      r_gdx, r_gdy, r_gdz;
    logic [XBits-1:0]      r_gx;
    logic [YBits-1:0]      r_gy;
    always_ff @(posedge i_clk) begin
        if (ring_we) r_ring[ring_addr] <= r_sample;
        r_ring_q <= r_ring[ring_addr];
    end
    always_comb begin
        ring_we = (r_state == ST_WRITE);
        if (r_state == ST_WRITE)
            ring_addr = {r_slot, r_y, r_x};
        else
            ring_addr = {r_gs, r_gy, r_gx};
    end

    // Gather bookkeeping.
    logic [WinBits-1:0] r_n, r_wa;
    logic               r_gv, r_gend;
    logic               r_last;
    t_sel_req           sel_req;
    logic               sel_done;
    logic [SampleBits-1:0] sel_val;
    logic [WinBits-1:0] r_total;

    always_comb begin
        sel_req.start = (r_state == ST_GATHER) && r_gend && !r_gv;
        sel_req.count = r_total;
        sel_req.rank  = (r_total - 1'b1) >> 1;
    end

    vmf_select u_sel (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_wr_en(r_state == ST_GATHER && r_gv), .i_wr_addr(r_wa), .i_wr_data(r_ring_q),
        .i_req(sel_req), .o_done(sel_done), .o_value(sel_val)
    );

    assign s_axis_tready = (r_state == ST_IDLE);

    // A register write takes priority; a finished median loads the output
    // register once it is free or being drained.
    logic cfg_hit, out_load;
    assign cfg_hit  = i_cfg_we && (i_cfg_idx <= REG_PAD_D);
    assign out_load = !cfg_hit && (r_state == ST_OUT) && (!m_axis_tvalid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_kx <= 3'd3; r_ky <= 3'd3; r_kz <= 3'd3;
            r_pw <= 8'd128; r_ph <= 8'd128; r_pd <= 13'd128;
            r_x <= '0; r_y <= '0; r_z <= '0; r_slot <= '0;
            m_axis_tvalid <= 1'b0;
            r_gv <= 1'b0; r_gend <= 1'b0;
        end else begin
            if (out_load) begin
                m_axis_tvalid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end
            if (cfg_hit) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_KERNEL_X: r_kx <= i_cfg_data[2:0];
                    REG_KERNEL_Y: r_ky <= i_cfg_data[2:0];
                    REG_KERNEL_Z: r_kz <= i_cfg_data[2:0];
                    REG_PAD_W:    r_pw <= i_cfg_data[7:0];
                    REG_PAD_H:    r_ph <= i_cfg_data[7:0];
                    REG_PAD_D:    r_pd <= i_cfg_data;
                    default: ;
                endcase
                r_x <= '0; r_y <= '0; r_z <= '0; r_slot <= '0;
            end else begin
                case (r_state)
                    ST_IDLE: begin
                        if (s_axis_tvalid && s_axis_tready) begin
                            r_sample <= s_axis_tdata;
                            r_state  <= ST_WRITE;
                        end
                    end
                    ST_WRITE: begin
                        r_last <= is_last;
                        if (win_ok) begin
                            // Window starts at slot of z0 = z+1-kz.
                            r_gs  <= (r_slot + 1'b1 >= kz) ? SlotBits'(r_slot + 1'b1 - kz)
                                     : SlotBits'(r_slot + 1'b1);
                            r_gdx <= '0; r_gdy <= '0; r_gdz <= '0;
                            r_gx  <= XBits'(r_x + 1'b1 - kx);
                            r_gy  <= YBits'(r_y + 1'b1 - ky);
                            r_n   <= '0;
                            r_total <= WinBits'(kx * ky * kz);
                            r_gv  <= 1'b0; r_gend <= 1'b0;
                            r_state <= ST_GATHER;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                        // Advance position.
                        if ({1'b0, r_x} + 1'b1 >= pw) begin
                            r_x <= '0;
                            if ({1'b0, r_y} + 1'b1 >= ph) begin
                                r_y <= '0;
                                if ({1'b0, r_z} + 1'b1 >= pd) begin
                                    r_z <= '0; r_slot <= '0;
                                end else begin
                                    r_z <= r_z + 1'b1;
                                    r_slot <= ({1'b0, r_slot} + 1'b1 >= kz) ? '0
                                              : r_slot + 1'b1;
                                end
                            end else r_y <= r_y + 1'b1;
                        end else r_x <= r_x + 1'b1;
                    end
                    ST_GATHER: begin
                        // Address issued this cycle, data written next cycle.
                        r_gv <= !r_gend;
                        r_wa <= r_n;
                        if (r_gend && !r_gv) begin
                            r_state <= ST_SELECT;
                        end else if (!r_gend) begin
                            r_n <= r_n + 1'b1;
                            if (r_n + 1'b1 == r_total) r_gend <= 1'b1;
                            if (r_gdx + 1'b1 == kx) begin
                                r_gdx <= '0;
                                r_gx  <= XBits'(r_gx + 1'b1 - kx);
                                if (r_gdy + 1'b1 == ky) begin
                                    r_gdy <= '0;
                                    r_gy  <= YBits'(r_gy + 1'b1 - ky);
                                    r_gdz <= r_gdz + 1'b1;
                                    r_gs  <= ({1'b0, r_gs} + 1'b1 >= kz) ? '0 : r_gs + 1'b1;
                                end else begin
                                    r_gdy <= r_gdy + 1'b1;
                                    r_gy  <= r_gy + 1'b1;
                                end
                            end else begin
                                r_gdx <= r_gdx + 1'b1;
                                r_gx  <= r_gx + 1'b1;
                            end
                        end
                    end
                    ST_SELECT: begin
                        if (sel_done) begin
                            r_state <= ST_OUT;
                        end
                    end
                    ST_OUT: begin
                        // The selection unit holds its value until the next request.
                        if (out_load) begin
                            m_axis_tdata <= sel_val;
                            m_axis_tlast <= r_last;
                            r_state      <= ST_IDLE;
                        end
                    end
                    default: r_state <= ST_IDLE;
                endcase
            end
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> r_state == ST_IDLE) else $error("ready while busy");
    a_out_from_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state) == ST_OUT) else $error("output without select");
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_slot} < kz || kz == 0) else $error("slot out of range");
endmodule
`default_nettype wire
